// ===== sv/dkw_pkg.sv =====
// ----------------------------------------------------------------------------
// dkw_pkg: shared types and constants of the dense key window ring store
// Command codes, status codes, and the controller to datapath interface.
// ----------------------------------------------------------------------------
package dkw_pkg;

  // Default number of ring slots.
  localparam int SLOTS_DEF = 512;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 9;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 10;
  localparam int CAPF_W  = 10;
  localparam int PADDR_W = 3;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET_KEY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET_POS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_SWITCH   = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_SWITCH   = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_RECENTER,
    OP_RD_ITEM,
    OP_FINISH_RW,
    OP_GROW_HEAD,
    OP_GROW_TAIL,
    OP_RD_TAIL,
    OP_TRIM_TAIL,
    OP_RD_HEAD,
    OP_TRIM_HEAD,
    OP_RES_OK,
    OP_RES_MISS,
    OP_RES_OVF,
    OP_OUT
  } dp_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             val_zero;
    logic             filled_zero;
    logic             in_win;
    logic             pos_ok;
    logic             below_head;
    logic             fits_low;
    logic             fits_high;
    logic             trimmed;
    logic             rdata_zero;
    logic             clr_last;
    logic             out_free;
    logic             cap_wr;
  } dp_stat_t;

endpackage

// ===== sv/dkw_ctrl.sv =====
// ----------------------------------------------------------------------------
// dkw_ctrl: controller of the dense key window ring store
// Sequences the clearing sweep, item decode, memory read-modify-write,
// window trimming, and result hand-off to the output register.
// ----------------------------------------------------------------------------
module dkw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dkw_pkg::dp_stat_t stat,
  output dkw_pkg::dp_op_t  op
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_TRD,
    S_TTRIM,
    S_HTRIM,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and datapath operation.
  always_comb begin
    state_nxt = state_r;
    op        = dkw_pkg::OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = dkw_pkg::OP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = dkw_pkg::OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_OUT;
        case (stat.cmd)
          dkw_pkg::CMD_GET_KEY: begin
            if (stat.in_win) begin
              op        = dkw_pkg::OP_RD_ITEM;
              state_nxt = S_RMW;
            end else begin
              op = dkw_pkg::OP_RES_MISS;
            end
          end
          dkw_pkg::CMD_GET_POS: begin
            if (stat.pos_ok) begin
              op        = dkw_pkg::OP_RD_ITEM;
              state_nxt = S_RMW;
            end else begin
              op = dkw_pkg::OP_RES_MISS;
            end
          end
          dkw_pkg::CMD_PUT: begin
            if (stat.val_zero) begin
              if (!stat.filled_zero && stat.in_win) begin
                op        = dkw_pkg::OP_RD_ITEM;
                state_nxt = S_RMW;
              end else begin
                op = dkw_pkg::OP_RES_OK;
              end
            end else if (stat.filled_zero) begin
              op = dkw_pkg::OP_RECENTER;
            end else if (stat.in_win) begin
              op        = dkw_pkg::OP_RD_ITEM;
              state_nxt = S_RMW;
            end else if (stat.below_head) begin
              if (stat.fits_low) begin
                op = dkw_pkg::OP_GROW_HEAD;
              end else if (stat.trimmed) begin
                op = dkw_pkg::OP_RES_OVF;
              end else begin
                op        = dkw_pkg::OP_RD_TAIL;
                state_nxt = S_TTRIM;
              end
            end else begin
              if (stat.fits_high) begin
                op = dkw_pkg::OP_GROW_TAIL;
              end else if (stat.trimmed) begin
                op = dkw_pkg::OP_RES_OVF;
              end else begin
                op        = dkw_pkg::OP_RD_HEAD;
                state_nxt = S_HTRIM;
              end
            end
          end
          default: begin
            op = dkw_pkg::OP_RES_OK;
          end
        endcase
      end
      S_RMW: begin
        op        = dkw_pkg::OP_FINISH_RW;
        state_nxt = S_OUT;
      end
      S_TRD: begin
        op        = dkw_pkg::OP_RD_TAIL;
        state_nxt = S_TTRIM;
      end
      S_TTRIM: begin
        // An empty slot at the tail end is dropped; a filled one ends the trim.
        if (stat.rdata_zero) begin
          op        = dkw_pkg::OP_TRIM_TAIL;
          state_nxt = S_TRD;
        end else begin
          state_nxt = S_DECODE;
        end
      end
      S_HTRIM: begin
        // Each head step also reads the new head slot, so the check repeats here.
        if (stat.rdata_zero) begin
          op        = dkw_pkg::OP_TRIM_HEAD;
          state_nxt = S_HTRIM;
        end else begin
          state_nxt = S_DECODE;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          op        = dkw_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State register; a capacity write restarts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else if (stat.cap_wr) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // A capacity write always starts a new clearing sweep.
  a_cap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cap_wr |=> (state_r == S_CLEAR))
    else $error("capacity write did not start a clearing sweep");

  // Items are taken only while idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dkw_pkg::OP_LOAD) |-> (state_r == S_IDLE) && in_valid)
    else $error("item loaded outside idle");

  // The output register is loaded only when it can take a result.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dkw_pkg::OP_OUT) |-> stat.out_free)
    else $error("result loaded over a waiting result");

endmodule

// ===== sv/dkw_dp.sv =====
// ----------------------------------------------------------------------------
// dkw_dp: datapath of the dense key window ring store
// Holds the slot memory, window pointers, entry count, configuration
// registers, item latch, and the output register.
// ----------------------------------------------------------------------------
module dkw_dp #(
  parameter int SLOTS = dkw_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dkw_pkg::dp_op_t               op,
  output dkw_pkg::dp_stat_t             stat,
  input  logic                          cap_wr,
  input  logic                          sw_wr,
  input  logic [31:0]                   cfg_wdata,
  output logic [dkw_pkg::CAPF_W-1:0]    cfg_cap,
  output logic                          cfg_sw,
  input  logic [dkw_pkg::CMD_W-1:0]     in_cmd,
  input  logic [dkw_pkg::KEY_W-1:0]     in_key,
  input  logic [dkw_pkg::POS_W-1:0]     in_position,
  input  logic [dkw_pkg::DATA_W-1:0]    in_data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dkw_pkg::STAT_W-1:0]    out_status,
  output logic [dkw_pkg::DATA_W-1:0]    out_data_out,
  output logic [dkw_pkg::KEY_W-1:0]     out_key_out,
  output logic [dkw_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Slot memory.
  logic [dkw_pkg::DATA_W-1:0] mem [SLOTS];
  logic [dkw_pkg::DATA_W-1:0] rdata_r;

  // Configuration, window, and item registers.
  logic [CW-1:0]                cap_r;
  logic                         sw_r;
  logic [AW-1:0]                head_slot_r;
  logic [AW-1:0]                tail_slot_r;
  logic [31:0]                  head_key_r;
  logic [32:0]                  tail_key_r;
  logic [CW-1:0]                filled_r;
  logic [AW-1:0]                clr_idx_r;
  logic [dkw_pkg::CMD_W-1:0]    cmd_r;
  logic [dkw_pkg::KEY_W-1:0]    key_r;
  logic [dkw_pkg::POS_W-1:0]    pos_r;
  logic [dkw_pkg::DATA_W-1:0]   val_r;
  logic                         trimmed_r;
  logic [dkw_pkg::STAT_W-1:0]   res_status_r;
  logic [dkw_pkg::DATA_W-1:0]   res_dout_r;
  logic [dkw_pkg::KEY_W-1:0]    res_kout_r;
  logic                         out_valid_r;
  logic [dkw_pkg::STAT_W-1:0]   out_status_r;
  logic [dkw_pkg::DATA_W-1:0]   out_data_r;
  logic [dkw_pkg::KEY_W-1:0]    out_key_r;
  logic [dkw_pkg::COUNT_W-1:0]  out_count_r;

  // Window tests on the latched item.
  logic [32:0] key33;
  logic [32:0] head33;
  logic [32:0] cap33;
  logic [32:0] size33;
  logic        in_win;
  logic        pos_ok;
  logic        fits_low;
  logic        fits_high;

  assign key33     = {1'b0, key_r};
  assign head33    = {1'b0, head_key_r};
  assign cap33     = 33'(cap_r);
  assign size33    = tail_key_r - head33;
  assign in_win    = (key33 >= head33) && (key33 < tail_key_r);
  assign pos_ok    = 33'(pos_r) < size33;
  assign fits_low  = (tail_key_r - key33) <= cap33;
  assign fits_high = (key33 + 33'd1 - head33) <= cap33;

  // Slot of the item: head plus offset, wrapped once at capacity.
  logic [CW-1:0] off;
  logic [CW:0]   isum;
  logic [AW-1:0] item_slot;

  always_comb begin
    if (cmd_r == dkw_pkg::CMD_GET_POS) begin
      off = CW'(pos_r);
    end else begin
      off = CW'(key33 - head33);
    end
    isum = (CW+1)'(head_slot_r) + (CW+1)'(off);
    if (isum >= (CW+1)'(cap_r)) begin
      item_slot = AW'(isum - (CW+1)'(cap_r));
    end else begin
      item_slot = AW'(isum);
    end
  end

  // Growth toward a lower key moves the head back by the key distance.
  logic [CW-1:0] n_head;
  logic [CW:0]   gh_sum;
  logic [AW-1:0] new_head;

  always_comb begin
    n_head = CW'(head_key_r - key_r);
    if (CW'(head_slot_r) >= n_head) begin
      gh_sum = (CW+1)'(CW'(head_slot_r) - n_head);
    end else begin
      gh_sum = (CW+1)'(head_slot_r) + (CW+1)'(cap_r) - (CW+1)'(n_head);
    end
    new_head = AW'(gh_sum);
  end

  // Growth toward a higher key moves the tail forward past the key.
  logic [CW-1:0] n_tail;
  logic [CW:0]   gt_sum;
  logic [AW-1:0] new_tail;
  logic [AW-1:0] tail_wslot;

  always_comb begin
    n_tail = CW'(key33 + 33'd1 - tail_key_r);
    gt_sum = (CW+1)'(tail_slot_r) + (CW+1)'(n_tail);
    if (gt_sum >= (CW+1)'(cap_r)) begin
      new_tail = AW'(gt_sum - (CW+1)'(cap_r));
    end else begin
      new_tail = AW'(gt_sum);
    end
    if (new_tail == '0) begin
      tail_wslot = AW'(cap_r - CW'(1));
    end else begin
      tail_wslot = new_tail - AW'(1);
    end
  end

  // Neighbors used by trimming.
  logic [AW-1:0] last_slot;
  logic [AW-1:0] head_next;

  always_comb begin
    if (tail_slot_r == '0) begin
      last_slot = AW'(cap_r - CW'(1));
    end else begin
      last_slot = tail_slot_r - AW'(1);
    end
    if ((CW'(head_slot_r) + CW'(1)) == cap_r) begin
      head_next = '0;
    end else begin
      head_next = head_slot_r + AW'(1);
    end
  end

  // Memory port selection.
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [dkw_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = item_slot;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = item_slot;
    case (op)
      dkw_pkg::OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      dkw_pkg::OP_RECENTER: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
      end
      dkw_pkg::OP_GROW_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = new_head;
      end
      dkw_pkg::OP_GROW_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = tail_wslot;
      end
      dkw_pkg::OP_FINISH_RW: begin
        mem_we = (cmd_r == dkw_pkg::CMD_PUT);
      end
      dkw_pkg::OP_RD_ITEM: begin
        mem_re = 1'b1;
      end
      dkw_pkg::OP_RD_TAIL: begin
        mem_re    = 1'b1;
        mem_raddr = last_slot;
      end
      dkw_pkg::OP_RD_HEAD, dkw_pkg::OP_TRIM_HEAD: begin
        // After a head step the new head slot is read right away.
        mem_re    = 1'b1;
        mem_raddr = (op == dkw_pkg::OP_TRIM_HEAD) ? head_next : head_slot_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Capacity write value, held to the legal range.
  logic [dkw_pkg::CAPF_W-1:0] cap_field;
  logic [CW-1:0]              cap_wv;

  always_comb begin
    cap_field = cfg_wdata[dkw_pkg::CAPF_W-1:0];
    if (cap_field == '0) begin
      cap_wv = CW'(1);
    end else if (int'(cap_field) > SLOTS) begin
      cap_wv = CW'(SLOTS);
    end else begin
      cap_wv = CW'(cap_field);
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // Control and window state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CW'(SLOTS);
      sw_r        <= 1'b0;
      head_slot_r <= '0;
      tail_slot_r <= '0;
      head_key_r  <= '0;
      tail_key_r  <= '0;
      filled_r    <= '0;
      clr_idx_r   <= '0;
      trimmed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (sw_wr) begin
        sw_r <= cfg_wdata[0];
      end
      if (op == dkw_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cap_wr) begin
        cap_r       <= cap_wv;
        head_slot_r <= '0;
        tail_slot_r <= '0;
        head_key_r  <= '0;
        tail_key_r  <= '0;
        filled_r    <= '0;
        clr_idx_r   <= '0;
      end else begin
        case (op)
          dkw_pkg::OP_CLEAR: begin
            clr_idx_r <= clr_idx_r + AW'(1);
          end
          dkw_pkg::OP_LOAD: begin
            trimmed_r <= 1'b0;
          end
          dkw_pkg::OP_RECENTER: begin
            head_key_r  <= key_r;
            head_slot_r <= '0;
            tail_slot_r <= (cap_r == CW'(1)) ? AW'(0) : AW'(1);
            tail_key_r  <= key33 + 33'd1;
            filled_r    <= filled_r + CW'(1);
          end
          dkw_pkg::OP_GROW_HEAD: begin
            head_slot_r <= new_head;
            head_key_r  <= key_r;
            filled_r    <= filled_r + CW'(1);
          end
          dkw_pkg::OP_GROW_TAIL: begin
            tail_slot_r <= new_tail;
            tail_key_r  <= key33 + 33'd1;
            filled_r    <= filled_r + CW'(1);
          end
          dkw_pkg::OP_FINISH_RW: begin
            if (cmd_r == dkw_pkg::CMD_PUT) begin
              if (val_r != '0 && rdata_r == '0) begin
                filled_r <= filled_r + CW'(1);
              end else if (val_r == '0 && rdata_r != '0) begin
                filled_r <= filled_r - CW'(1);
              end
            end
          end
          dkw_pkg::OP_RD_TAIL, dkw_pkg::OP_RD_HEAD: begin
            trimmed_r <= 1'b1;
          end
          dkw_pkg::OP_TRIM_TAIL: begin
            tail_slot_r <= last_slot;
            tail_key_r  <= tail_key_r - 33'd1;
          end
          dkw_pkg::OP_TRIM_HEAD: begin
            head_slot_r <= head_next;
            head_key_r  <= head_key_r + 32'd1;
          end
          default: begin
            clr_idx_r <= clr_idx_r;
          end
        endcase
      end
    end
  end

  // Item latch, result, and output payload.
  always_ff @(posedge clk) begin
    if (op == dkw_pkg::OP_LOAD) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      pos_r <= in_position;
      val_r <= in_data_in;
    end
    case (op)
      dkw_pkg::OP_RECENTER, dkw_pkg::OP_GROW_HEAD, dkw_pkg::OP_GROW_TAIL,
      dkw_pkg::OP_RES_OK: begin
        res_status_r <= dkw_pkg::ST_OK;
        res_dout_r   <= '0;
        res_kout_r   <= '0;
      end
      dkw_pkg::OP_RES_MISS: begin
        res_status_r <= dkw_pkg::ST_MISS;
        res_dout_r   <= '0;
        res_kout_r   <= '0;
      end
      dkw_pkg::OP_RES_OVF: begin
        res_status_r <= sw_r ? dkw_pkg::ST_SWITCH : dkw_pkg::ST_OVERFLOW;
        res_dout_r   <= '0;
        res_kout_r   <= '0;
      end
      dkw_pkg::OP_FINISH_RW: begin
        res_status_r <= dkw_pkg::ST_OK;
        res_dout_r   <= (cmd_r == dkw_pkg::CMD_PUT) ? '0 : rdata_r;
        res_kout_r   <= (cmd_r == dkw_pkg::CMD_GET_POS) ?
                        (head_key_r + 32'(pos_r)) : '0;
      end
      default: begin
        res_status_r <= res_status_r;
      end
    endcase
    if (op == dkw_pkg::OP_OUT) begin
      out_status_r <= res_status_r;
      out_data_r   <= res_dout_r;
      out_key_r    <= res_kout_r;
      out_count_r  <= dkw_pkg::COUNT_W'(filled_r);
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.cmd         = cmd_r;
    stat.val_zero    = (val_r == '0);
    stat.filled_zero = (filled_r == '0);
    stat.in_win      = in_win;
    stat.pos_ok      = pos_ok;
    stat.below_head  = (key_r < head_key_r);
    stat.fits_low    = fits_low;
    stat.fits_high   = fits_high;
    stat.trimmed     = trimmed_r;
    stat.rdata_zero  = (rdata_r == '0);
    stat.clr_last    = (clr_idx_r == AW'(SLOTS - 1));
    stat.out_free    = out_free;
    stat.cap_wr      = cap_wr;
  end

  assign cfg_cap         = dkw_pkg::CAPF_W'(cap_r);
  assign cfg_sw          = sw_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_key_out     = out_key_r;
  assign out_entry_count = out_count_r;

  // The window never covers more slots than the configured capacity.
  a_win_size: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_key_r - head33) <= cap33)
    else $error("key window exceeds capacity");

  // Ring pointers stay inside the slots in use.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(head_slot_r) < cap_r) && (CW'(tail_slot_r) < cap_r))
    else $error("ring pointer beyond capacity");

  // The entry count cannot exceed the window.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    33'(filled_r) <= (tail_key_r - head33))
    else $error("entry count larger than window");

endmodule

// ===== sv/dense_key_window_ring_store.sv =====
// ----------------------------------------------------------------------------
// dense_key_window_ring_store: keyed window store over a ring of slots
// Flow: an accepted item is latched and decoded; a get or an in-window put then
// reads its slot and finishes a read-modify-write; a put that must trim first
// reads and drops empty slots at the tail or head end, then decodes again.
// One transaction at a time; output stalls delay the hand-off of the result.
// Reset and every capacity write run a clearing pass over all SLOTS slots, in_stall high.
// ----------------------------------------------------------------------------
module dense_key_window_ring_store #(
  parameter int SLOTS = dkw_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dkw_pkg::CMD_W-1:0]     in_cmd,
  input  logic [dkw_pkg::KEY_W-1:0]     in_key,
  input  logic [dkw_pkg::POS_W-1:0]     in_position,
  input  logic [dkw_pkg::DATA_W-1:0]    in_data_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dkw_pkg::STAT_W-1:0]    out_status,
  output logic [dkw_pkg::DATA_W-1:0]    out_data_out,
  output logic [dkw_pkg::KEY_W-1:0]     out_key_out,
  output logic [dkw_pkg::COUNT_W-1:0]   out_entry_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dkw_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  dkw_pkg::dp_op_t   op;
  dkw_pkg::dp_stat_t stat;
  logic [dkw_pkg::CAPF_W-1:0] cfg_cap;
  logic                       cfg_sw;
  logic                       wr_en;
  logic                       cap_wr;
  logic                       sw_wr;

  // Register write decode; the word address selects the register.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cap_wr = wr_en && (paddr[2] == dkw_pkg::REG_CAPACITY);
  assign sw_wr  = wr_en && (paddr[2] == dkw_pkg::REG_SWITCH);

  // Register read back.
  always_comb begin
    if (paddr[2] == dkw_pkg::REG_SWITCH) begin
      prdata = {31'b0, cfg_sw};
    end else begin
      prdata = 32'(cfg_cap);
    end
  end

  dkw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  dkw_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .stat            (stat),
    .cap_wr          (cap_wr),
    .sw_wr           (sw_wr),
    .cfg_wdata       (pwdata),
    .cfg_cap         (cfg_cap),
    .cfg_sw          (cfg_sw),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_position     (in_position),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_key_out     (out_key_out),
    .out_entry_count (out_entry_count)
  );

endmodule

// ===== tb/dkw_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dkw_checker: result checker for the dense key window ring store
// Watches the input channel, the configuration writes and the result channel,
// predicts each result from its own model of the key window, and compares.
// ----------------------------------------------------------------------------
module dkw_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [dkw_pkg::CMD_W-1:0]   in_cmd,
  input  logic [dkw_pkg::KEY_W-1:0]   in_key,
  input  logic [dkw_pkg::POS_W-1:0]   in_position,
  input  logic [dkw_pkg::DATA_W-1:0]  in_data_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [dkw_pkg::STAT_W-1:0]  out_status,
  input  logic [dkw_pkg::DATA_W-1:0]  out_data_out,
  input  logic [dkw_pkg::KEY_W-1:0]   out_key_out,
  input  logic [dkw_pkg::COUNT_W-1:0] out_entry_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dkw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending
);

  typedef struct {
    logic [dkw_pkg::STAT_W-1:0]  status;
    logic [dkw_pkg::DATA_W-1:0]  data_out;
    logic [dkw_pkg::KEY_W-1:0]   key_out;
    logic [dkw_pkg::COUNT_W-1:0] entry_count;
  } window_result_t;

  window_result_t results_due[$];

  // Model of the window: slot values, ring indexes and key bounds.
  logic [31:0] ring[dkw_pkg::SLOTS_DEF];
  longint      head_s, tail_s, head_key, tail_key, filled, cap;
  bit          sw_allowed;

  function automatic void wipe_window();
    foreach (ring[i]) ring[i] = '0;
    head_s = 0;
    tail_s = 0;
    head_key = 0;
    tail_key = 0;
    filled = 0;
  endfunction

  function automatic longint ring_slot(longint offset);
    return (head_s + offset) % cap;
  endfunction

  // Extend the window so that it covers the key, trimming empty far slots first.
  function automatic logic [dkw_pkg::STAT_W-1:0] widen_to(longint k);
    longint n;
    longint last;
    if (filled == 0) begin
      head_key = k;
      head_s = 0;
      tail_s = 1 % cap;
      tail_key = k + 1;
      ring[0] = '0;
      return dkw_pkg::ST_OK;
    end
    if (k < head_key) begin
      if (tail_key - k > cap) begin
        while (tail_key > head_key) begin
          last = (tail_s + cap - 1) % cap;
          if (ring[last] != 0) break;
          tail_s = last;
          tail_key--;
        end
      end
      if (tail_key - k > cap)
        return sw_allowed ? dkw_pkg::ST_SWITCH : dkw_pkg::ST_OVERFLOW;
      n = head_key - k;
      head_s = (head_s + cap - (n % cap)) % cap;
      for (longint i = 0; i < n; i++) ring[ring_slot(i)] = '0;
      head_key = k;
    end else if (k >= tail_key) begin
      if (k + 1 - head_key > cap) begin
        while (head_key < tail_key && ring[head_s] == 0) begin
          head_s = (head_s + 1) % cap;
          head_key++;
        end
      end
      if (k + 1 - head_key > cap)
        return sw_allowed ? dkw_pkg::ST_SWITCH : dkw_pkg::ST_OVERFLOW;
      n = k + 1 - tail_key;
      for (longint i = 0; i < n; i++) ring[(tail_s + i) % cap] = '0;
      tail_s = (tail_s + n) % cap;
      tail_key = k + 1;
    end
    return dkw_pkg::ST_OK;
  endfunction

  // Apply one transaction to the model and return the result it causes.
  function automatic window_result_t apply_item(logic [dkw_pkg::CMD_W-1:0] cmd,
                                                logic [31:0] key,
                                                logic [dkw_pkg::POS_W-1:0] pos,
                                                logic [31:0] val);
    window_result_t r;
    longint k;
    longint s;
    bit hit;
    k = longint'(key);
    r.status = dkw_pkg::ST_OK;
    r.data_out = '0;
    r.key_out = '0;
    hit = (k >= head_key) && (k < tail_key);
    if (cmd == dkw_pkg::CMD_PUT) begin
      if (val == 0) begin
        if (filled != 0 && hit) begin
          s = ring_slot(k - head_key);
          if (ring[s] != 0) begin
            ring[s] = '0;
            filled--;
          end
        end
      end else begin
        r.status = widen_to(k);
        if (r.status == dkw_pkg::ST_OK) begin
          s = ring_slot(k - head_key);
          if (ring[s] == 0) filled++;
          ring[s] = val;
        end
      end
    end else if (cmd == dkw_pkg::CMD_GET_KEY) begin
      if (hit) r.data_out = ring[ring_slot(k - head_key)];
      else r.status = dkw_pkg::ST_MISS;
    end else if (cmd == dkw_pkg::CMD_GET_POS) begin
      if (longint'(pos) < tail_key - head_key) begin
        r.key_out = 32'(head_key + longint'(pos));
        r.data_out = ring[ring_slot(longint'(pos))];
      end else begin
        r.status = dkw_pkg::ST_MISS;
      end
    end
    r.entry_count = dkw_pkg::COUNT_W'(filled);
    return r;
  endfunction

  // Track configuration writes, accepted items and accepted results.
  always @(posedge clk) begin
    window_result_t want;
    longint v;
    int errs;
    errs = 0;
    if (!rst_n) begin
      cap = dkw_pkg::SLOTS_DEF;
      sw_allowed = 0;
      wipe_window();
      results_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == dkw_pkg::REG_CAPACITY) begin
          v = longint'(pwdata[9:0]);
          if (v < 1) v = 1;
          if (v > dkw_pkg::SLOTS_DEF) v = dkw_pkg::SLOTS_DEF;
          cap = v;
          wipe_window();
        end else begin
          sw_allowed = pwdata[0];
        end
      end
      if (in_valid && !in_stall)
        results_due.insert(results_due.size(),
                           apply_item(in_cmd, in_key, in_position, in_data_in));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errs++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_data_out !== want.data_out) begin
            $error("data_out: expected %h, actual %h", want.data_out, out_data_out);
            errs++;
          end
          if (out_key_out !== want.key_out) begin
            $error("key_out: expected %h, actual %h", want.key_out, out_key_out);
            errs++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   out_entry_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= results_due.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the dense key window ring store
// Drives directed and random puts and gets through several capacity and
// switch settings, with random idle gaps and result stalls.
// ----------------------------------------------------------------------------
module testbench;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [dkw_pkg::CMD_W-1:0]   in_cmd = '0;
  logic [dkw_pkg::KEY_W-1:0]   in_key = '0;
  logic [dkw_pkg::POS_W-1:0]   in_position = '0;
  logic [dkw_pkg::DATA_W-1:0]  in_data_in = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [dkw_pkg::STAT_W-1:0]  out_status;
  logic [dkw_pkg::DATA_W-1:0]  out_data_out;
  logic [dkw_pkg::KEY_W-1:0]   out_key_out;
  logic [dkw_pkg::COUNT_W-1:0] out_entry_count;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [dkw_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  int                          fail_count;
  int                          pending;
  bit                          steady = 1'b0;
  int                          stall_hold = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dense_key_window_ring_store u_top (.*);

  dkw_checker u_checker (.*);

  // Random result stalls, mostly short with an occasional long one, and
  // stretches of none.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (steady) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall <= (r < 60);
    end else if (r < 2) begin
      out_stall <= 1'b1;
      stall_hold <= int'($urandom_range(8, 40));
    end else begin
      out_stall <= (r < 20);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (steady || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic send_item(logic [dkw_pkg::CMD_W-1:0] cmd, logic [31:0] key,
                           logic [dkw_pkg::POS_W-1:0] pos, logic [31:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_key <= key;
    in_position <= pos;
    in_data_in <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let every result arrive, then let any trim or clear still running finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random items keyed around a moving base so the window grows, trims and overflows.
  task automatic random_phase(int count, int span);
    logic [31:0] base;
    logic [31:0] key;
    logic [31:0] val;
    logic [dkw_pkg::CMD_W-1:0] cmd;
    int r;
    base = $urandom();
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) base = $urandom();
      r = $urandom_range(0, 99);
      if (r < 50) cmd = dkw_pkg::CMD_PUT;
      else if (r < 72) cmd = dkw_pkg::CMD_GET_KEY;
      else if (r < 95) cmd = dkw_pkg::CMD_GET_POS;
      else cmd = dkw_pkg::CMD_NONE;
      if ($urandom_range(0, 19) == 0) key = $urandom();
      else key = base + $urandom_range(0, 2 * span + 8) - span - 4;
      val = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom();
      send_item(cmd, key, 9'($urandom_range(0, (span < 511) ? span + 4 : 511)) |
                (($urandom_range(0, 9) == 0) ? 9'($urandom()) : 9'h0), val);
    end
    steady = 1'b0;
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every command, deletes and misses.
    send_item(dkw_pkg::CMD_GET_KEY, 32'h0, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_GET_POS, 32'h0, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'h5, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'hFFFF_FFFF, 9'h0, 32'hFFFF_FFFF);
    send_item(dkw_pkg::CMD_GET_KEY, 32'hFFFF_FFFF, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_GET_POS, 32'h0, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'hFFFF_FE00, 9'h0, 32'h1234_5678);
    send_item(dkw_pkg::CMD_PUT, 32'hFFFF_FDFF, 9'h0, 32'h1);
    send_item(dkw_pkg::CMD_GET_POS, 32'h0, 9'h1FF, 32'h0);
    send_item(dkw_pkg::CMD_GET_POS, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);
    send_item(dkw_pkg::CMD_NONE, 32'hFFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);
    send_item(dkw_pkg::CMD_PUT, 32'hFFFF_FFFF, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'hFFFF_FFFF, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'h0, 9'h0, 32'hA5A5_A5A5);
    send_item(dkw_pkg::CMD_GET_KEY, 32'h0, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_GET_KEY, 32'h1, 9'h0, 32'h0);
    drain();
    reg_write(dkw_pkg::REG_SWITCH, 32'hFFFF_FFFF);
    send_item(dkw_pkg::CMD_PUT, 32'h8000_0000, 9'h0, 32'h7);
    send_item(dkw_pkg::CMD_PUT, 32'h0, 9'h0, 32'h0);
    send_item(dkw_pkg::CMD_PUT, 32'h1FF, 9'h0, 32'h9);
    send_item(dkw_pkg::CMD_GET_POS, 32'h0, 9'h1FF, 32'h0);
    drain();

    // Random phases over capacities, including out of range writes.
    reg_write(dkw_pkg::REG_CAPACITY, 32'hFFFF_FC00 | 32'd1);
    reg_write(dkw_pkg::REG_SWITCH, 32'h0);
    random_phase(140, 3);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd0);
    reg_write(dkw_pkg::REG_SWITCH, $urandom() | 32'd1);
    random_phase(80, 2);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd2);
    random_phase(140, 4);
    reg_write(dkw_pkg::REG_CAPACITY, 32'h0000_03FF);
    reg_write(dkw_pkg::REG_SWITCH, $urandom() & 32'hFFFF_FFFE);
    random_phase(120, 600);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd7);
    random_phase(150, 10);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd16);
    reg_write(dkw_pkg::REG_SWITCH, $urandom());
    random_phase(160, 24);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd511);
    random_phase(100, 520);
    reg_write(dkw_pkg::REG_CAPACITY, 32'h5A5A_A5C3 & 32'hFFFF_FC3F);
    random_phase(120, 70);
    reg_write(dkw_pkg::REG_CAPACITY, 32'd512);
    reg_write(dkw_pkg::REG_SWITCH, 32'h1);
    random_phase(120, 540);

    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
